// ===== src/assert_macros.svh =====
// Assertion macros for the point generator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

// ===== src/hpg_pkg.sv =====
// Types, constants and helper functions of the Halton point generator
`timescale 1ns / 1ps

package hpg_pkg;

    localparam int SAMPLE_W = 20;
    localparam int BASE_W   = 5;
    localparam int COORD_W  = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CHUNK_W  = 16;

    localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;

    // configuration register map
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT = 3'd5;

    // commands from the controller to both axis datapaths
    typedef struct packed {
        logic load;
        logic dig_mul;
        logic dig_fix;
        logic frac_step;
        logic scale_mul;
        logic scale_acc;
        logic place;
    } hpg_cmd_t;

    // status back to the controller
    typedef struct packed {
        logic x_done;
        logic y_done;
    } hpg_stat_t;

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        if (b < BASE_MIN)
            r = BASE_MIN;
        else if (b > BASE_MAX)
            r = BASE_MAX;
        else
            r = b;
        return r;
    endfunction

    // floor(2^32 / b) for the legal bases
    function automatic logic [31:0] recip32(input logic [BASE_W-1:0] b);
        logic [31:0] r;
        unique case (b)
            5'd2:    r = 32'h8000_0000;
            5'd3:    r = 32'h5555_5555;
            5'd4:    r = 32'h4000_0000;
            5'd5:    r = 32'h3333_3333;
            5'd6:    r = 32'h2AAA_AAAA;
            5'd7:    r = 32'h2492_4924;
            5'd8:    r = 32'h2000_0000;
            5'd9:    r = 32'h1C71_C71C;
            5'd10:   r = 32'h1999_9999;
            5'd11:   r = 32'h1745_D174;
            5'd12:   r = 32'h1555_5555;
            5'd13:   r = 32'h13B1_3B13;
            5'd14:   r = 32'h1249_2492;
            5'd15:   r = 32'h1111_1111;
            5'd16:   r = 32'h1000_0000;
            default: r = 32'h8000_0000;
        endcase
        return r;
    endfunction

endpackage

// ===== src/hpg_ctrl.sv =====
// Sequencer for the digit loop, fraction division, scaling and placement
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hpg_ctrl
    import hpg_pkg::*;
#(
    parameter int FRAC_BITS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  hpg_stat_t stat,
    output logic      busy,
    output logic      done,
    output hpg_cmd_t  cmd
);

    localparam int SCALE_STEPS = (FRAC_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int CW = $clog2(FRAC_BITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DMUL,
        S_DFIX,
        S_FRAC,
        S_SCALE,
        S_PLACE
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            done_reg, done_next;
    logic            all_done;

    assign all_done = stat.x_done && stat.y_done;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_DMUL;
            end
            S_DMUL:
            begin
                if (all_done)
                begin
                    state_next = S_FRAC;
                    cnt_next   = '0;
                end
                else
                    state_next = S_DFIX;
            end
            S_DFIX:
                state_next = S_DMUL;
            S_FRAC:
            begin
                if (cnt_reg == CW'(FRAC_BITS - 1))
                begin
                    state_next = S_SCALE;
                    cnt_next   = '0;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_SCALE:
            begin
                if (cnt_reg == CW'(SCALE_STEPS))
                    state_next = S_PLACE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_PLACE:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        cmd.load      = (state_reg == S_IDLE) && start;
        cmd.dig_mul   = (state_reg == S_DMUL) && !all_done;
        cmd.dig_fix   = (state_reg == S_DFIX);
        cmd.frac_step = (state_reg == S_FRAC);
        cmd.scale_mul = (state_reg == S_SCALE) && (cnt_reg < CW'(SCALE_STEPS));
        cmd.scale_acc = (state_reg == S_SCALE) && (cnt_reg != '0);
        cmd.place     = (state_reg == S_PLACE);
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    `ASSERT_CLK(a_done_single, done_reg |=> !done_reg, "result strobe longer than one cycle")
    `ASSERT_CLK(a_done_after_place, done_reg |-> $past(state_reg == S_PLACE), "result strobe without placement")
    `ASSERT_CLK(a_accept_starts, (start && !busy) |=> (state_reg == S_DMUL), "accepted item did not start the digit loop")
    `ASSERT_CLK(a_cmd_excl, $onehot0({cmd.load, cmd.dig_mul, cmd.dig_fix, cmd.frac_step, cmd.place}), "overlapping datapath commands")
    `ASSERT_NEVER(a_frac_overrun, (state_reg == S_FRAC) && (cnt_reg >= CW'(FRAC_BITS)), "fraction division ran past its length")

endmodule

// ===== src/hpg_axis.sv =====
// One axis: radical inverse digits, fraction division, scaling and saturating placement
`timescale 1ns / 1ps

module hpg_axis
    import hpg_pkg::*;
#(
    parameter int INDEX_BITS = 20,
    parameter int FRAC_BITS  = 32
)
(
    input  logic                      clk,
    input  hpg_cmd_t                  cmd,
    input  logic [INDEX_BITS-1:0]     idx,
    input  logic [BASE_W-1:0]         base,
    input  logic [COORD_W-1:0]        origin,
    input  logic [COORD_W-1:0]        size,
    output logic                      digits_done,
    output logic [COORD_W-1:0]        point
);

    localparam int K  = INDEX_BITS;
    localparam int DW = INDEX_BITS + 4;
    localparam int SCALE_STEPS = (FRAC_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int FP = SCALE_STEPS * CHUNK_W;
    localparam int AW = FP + COORD_W;
    localparam int PW = CHUNK_W + COORD_W;

    logic [BASE_W-1:0]  base_reg, base_next;
    logic [K-1:0]       n_reg, n_next;
    logic [2*K-1:0]     prod_reg, prod_next;
    logic [DW-1:0]      rev_reg, rev_next;
    logic [DW-1:0]      den_reg, den_next;
    logic [FP-1:0]      frac_reg, frac_next;
    logic [PW-1:0]      sprod_reg, sprod_next;
    logic [AW-1:0]      acc_reg, acc_next;
    logic [COORD_W-1:0] point_reg, point_next;

    logic [31:0]        rcp32;
    logic [K-1:0]       rcp;
    logic [K-1:0]       q0;
    logic [10:0]        qb;
    logic [5:0]         r6;
    logic               r_ge;
    logic [4:0]         digit;
    logic [DW+4:0]      rev_mul;
    logic [DW+4:0]      den_mul;
    logic [DW:0]        rem_sh;
    logic               rem_ge;
    logic [COORD_W-1:0] scaled;
    logic [COORD_W+1:0] sum;

    assign rcp32 = recip32(base_reg);
    assign rcp   = rcp32[31 -: K];

    // quotient estimate is exact or one short; remainder fits in six bits
    assign q0      = prod_reg[2*K-1:K];
    assign qb      = {5'b0, q0[5:0]} * {6'b0, base_reg};
    assign r6      = n_reg[5:0] - qb[5:0];
    assign r_ge    = (r6 >= {1'b0, base_reg});
    assign digit   = r_ge ? (r6[4:0] - base_reg) : r6[4:0];
    assign rev_mul = {5'b0, rev_reg} * {{DW{1'b0}}, base_reg};
    assign den_mul = {5'b0, den_reg} * {{DW{1'b0}}, base_reg};

    assign rem_sh  = {rev_reg, 1'b0};
    assign rem_ge  = (rem_sh >= {1'b0, den_reg});

    assign scaled  = acc_reg[FRAC_BITS +: COORD_W];
    assign sum     = {{2{origin[COORD_W-1]}}, origin} + {2'b00, scaled};

    always_comb
    begin
        base_next  = base_reg;
        n_next     = n_reg;
        prod_next  = prod_reg;
        rev_next   = rev_reg;
        den_next   = den_reg;
        frac_next  = frac_reg;
        sprod_next = sprod_reg;
        acc_next   = acc_reg;
        point_next = point_reg;

        if (cmd.load)
        begin
            base_next = base;
            n_next    = idx;
            rev_next  = '0;
            den_next  = DW'(1);
            frac_next = '0;
            acc_next  = '0;
        end

        if (cmd.dig_mul)
            prod_next = {{K{1'b0}}, n_reg} * {{K{1'b0}}, rcp};

        if (cmd.dig_fix && (n_reg != '0))
        begin
            n_next   = q0 + {{(K-1){1'b0}}, r_ge};
            rev_next = rev_mul[DW-1:0] + {{(DW-5){1'b0}}, digit};
            den_next = den_mul[DW-1:0];
        end

        // restoring division, rev_reg doubles as the running remainder
        if (cmd.frac_step)
        begin
            rev_next  = rem_ge ? (rem_sh[DW-1:0] - den_reg) : rem_sh[DW-1:0];
            frac_next = {frac_reg[FP-2:0], rem_ge};
        end

        if (cmd.scale_mul)
        begin
            sprod_next = {{COORD_W{1'b0}}, frac_reg[FP-1 -: CHUNK_W]}
                       * {{CHUNK_W{1'b0}}, size};
            frac_next  = frac_reg << CHUNK_W;
        end

        if (cmd.scale_acc)
            acc_next = {acc_reg[AW-CHUNK_W-1:0], {CHUNK_W{1'b0}}}
                     + {{(AW-PW){1'b0}}, sprod_reg};

        if (cmd.place)
        begin
            if (!sum[COORD_W+1] && (sum[COORD_W:COORD_W-1] != 2'b00))
                point_next = {1'b0, {(COORD_W-1){1'b1}}};
            else if (sum[COORD_W+1] && (sum[COORD_W:COORD_W-1] != 2'b11))
                point_next = {1'b1, {(COORD_W-1){1'b0}}};
            else
                point_next = sum[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        n_reg     <= n_next;
        prod_reg  <= prod_next;
        rev_reg   <= rev_next;
        den_reg   <= den_next;
        frac_reg  <= frac_next;
        sprod_reg <= sprod_next;
        acc_reg   <= acc_next;
        point_reg <= point_next;
    end

    assign digits_done = (n_reg == '0);
    assign point       = point_reg;

endmodule

// ===== src/halton_point_generator_top.sv =====
// Top level of the 2D Halton point generator: configuration registers and hookup
`timescale 1ns / 1ps

// Usage
//  Command channel: an index is taken at a rising edge with start high and busy low;
//  sample_index and last_in are captured then. busy stays high while the point is
//  being worked out.
//  Result: done pulses for one cycle with point_x, point_y and last_out valid in
//  that cycle. The receiver cannot stall, so it must take the result then.
//  busy is already low in the done cycle, so the next index may be taken at once.
//  The digit loop runs until the index has no digits left in either base, so
//  its length is set by the number of digits of the index in the smaller base
//  (at most 20 for base 2); no new index is taken before the last one is done.
//  Each digit takes a reciprocal multiply, then the remainder correction; the
//  fraction comes from a one-bit-per-cycle restoring divider, and scaling uses
//  a 32x16 multiplier over 16-bit slices.
//  Configuration: write channel cfg_valid/cfg_ready (ready always high), index
//  0..5 = base_x, base_y, origin_x, origin_y, view_width, view_height; other
//  indexes are dropped. Write only while the block is idle.
//  Reset: rst_n clears the sequencer and loads the default registers
//  (bases 2 and 3, origin 0, size 1.0); no clearing pass is needed.
module halton_point_generator_top
    import hpg_pkg::*;
#(
    parameter int INDEX_BITS = 20,
    parameter int FRAC_BITS  = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [SAMPLE_W-1:0]        sample_index,
    input  logic                       last_in,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [COORD_W-1:0]         cfg_data,
    output logic                       done,
    output logic signed [COORD_W-1:0]  point_x,
    output logic signed [COORD_W-1:0]  point_y,
    output logic                       last_out
);

    logic [BASE_W-1:0]  base_x_reg, base_y_reg;
    logic [COORD_W-1:0] origin_x_reg, origin_y_reg;
    logic [COORD_W-1:0] width_reg, height_reg;
    logic               last_reg;

    hpg_cmd_t           cmd;
    hpg_stat_t          stat;
    logic               x_done, y_done;
    logic [31:0]        idx_ext;
    logic [INDEX_BITS-1:0] idx;
    logic [COORD_W-1:0] px, py;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_x_reg   <= 5'd2;
            base_y_reg   <= 5'd3;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            width_reg    <= 32'h0001_0000;
            height_reg   <= 32'h0001_0000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BASE_X:      base_x_reg   <= cfg_data[BASE_W-1:0];
                CFG_BASE_Y:      base_y_reg   <= cfg_data[BASE_W-1:0];
                CFG_ORIGIN_X:    origin_x_reg <= cfg_data;
                CFG_ORIGIN_Y:    origin_y_reg <= cfg_data;
                CFG_VIEW_WIDTH:  width_reg    <= cfg_data;
                CFG_VIEW_HEIGHT: height_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // batch mark rides alongside the item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            last_reg <= last_in;
    end

    assign idx_ext = {{(32-SAMPLE_W){1'b0}}, sample_index};
    assign idx     = idx_ext[INDEX_BITS-1:0];

    assign stat = '{x_done: x_done, y_done: y_done};

    hpg_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    hpg_axis #(
        .INDEX_BITS (INDEX_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_axis_x (
        .clk         (clk),
        .cmd         (cmd),
        .idx         (idx),
        .base        (clamp_base(base_x_reg)),
        .origin      (origin_x_reg),
        .size        (width_reg),
        .digits_done (x_done),
        .point       (px)
    );

    hpg_axis #(
        .INDEX_BITS (INDEX_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_axis_y (
        .clk         (clk),
        .cmd         (cmd),
        .idx         (idx),
        .base        (clamp_base(base_y_reg)),
        .origin      (origin_y_reg),
        .size        (height_reg),
        .digits_done (y_done),
        .point       (py)
    );

    assign point_x  = px;
    assign point_y  = py;
    assign last_out = last_reg;

endmodule

// ===== dv/tb_halton_point_generator_top.sv =====
// Self-checking testbench for the 2D Halton point generator top level
`timescale 1ns / 1ps

module tb_halton_point_generator_top
    import hpg_pkg::*;
;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;
    localparam int     RANDOM_POINTS = 1350;
    localparam int     STALL_LIMIT   = 2000;
    localparam longint COORD_MAX     = 64'sd2147483647;
    localparam longint COORD_MIN     = -64'sd2147483648;

    typedef enum logic [1:0] {OP_POINT, OP_REG_WRITE, OP_SETTLE} op_kind_e;

    typedef struct {
        op_kind_e              kind;
        logic                  gappy;
        logic [SAMPLE_W-1:0]   index;
        logic                  last;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [COORD_W-1:0]    value;
    } pending_op_t;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } point_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [SAMPLE_W-1:0]        sample_index;
    logic                       last_in;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [COORD_W-1:0]         cfg_data;
    logic                       done;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic                       last_out;

    pending_op_t pending_ops[$];
    point_t      points_due[$];
    pending_op_t head_op;
    point_t      got_point;

    // shadow copy of the configuration registers
    logic [BASE_W-1:0]  cur_base_x;
    logic [BASE_W-1:0]  cur_base_y;
    logic [COORD_W-1:0] cur_origin_x;
    logic [COORD_W-1:0] cur_origin_y;
    logic [COORD_W-1:0] cur_width;
    logic [COORD_W-1:0] cur_height;

    logic item_taken;
    logic cfg_taken;
    int   errors;
    int   points_checked;
    int   reg_writes;
    int   quiet_cycles;

    halton_point_generator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sample_index (sample_index),
        .last_in      (last_in),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .point_x      (point_x),
        .point_y      (point_y),
        .last_out     (last_out)
    );

    always #5 clk = ~clk;

    // floor(radical inverse of idx in the given radix * 2^32)
    function automatic logic [31:0] radical_fraction(input logic [SAMPLE_W-1:0] idx,
                                                      input logic [BASE_W-1:0] radix);
        longint unsigned b;
        longint unsigned n;
        longint unsigned rev;
        longint unsigned den;
        longint unsigned rem;
        logic [31:0]     q;
        b = (radix < 2) ? 2 : ((radix > 16) ? 16 : radix);
        n = idx;
        rev = 0;
        den = 1;
        q = '0;
        while (n != 0)
        begin
            rev = rev * b + n % b;
            n = n / b;
            den = den * b;
        end
        rem = rev;
        for (int i = 0; i < 32; i++)
        begin
            rem = rem << 1;
            q = {q[30:0], rem >= den};
            if (rem >= den)
                rem = rem - den;
        end
        return q;
    endfunction

    function automatic logic [COORD_W-1:0] place_coord(input logic [COORD_W-1:0] origin,
                                                        input logic [31:0] frac,
                                                        input logic [COORD_W-1:0] size);
        logic [63:0] prod;
        longint      scaled;
        longint      sum;
        prod = {32'd0, frac} * {32'd0, size};
        scaled = prod[63:32];
        sum = longint'($signed(origin)) + scaled;
        if (sum > COORD_MAX)
            sum = COORD_MAX;
        if (sum < COORD_MIN)
            sum = COORD_MIN;
        return sum[COORD_W-1:0];
    endfunction

    function automatic point_t predict_point(input logic [SAMPLE_W-1:0] idx, input logic last);
        point_t p;
        p.x = place_coord(cur_origin_x, radical_fraction(idx, cur_base_x), cur_width);
        p.y = place_coord(cur_origin_y, radical_fraction(idx, cur_base_y), cur_height);
        p.last = last;
        return p;
    endfunction

    task automatic push_point(input logic [SAMPLE_W-1:0] idx, input logic last,
                              input logic gappy);
        pending_op_t op;
        op = '{OP_POINT, gappy, idx, last, '0, '0};
        pending_ops.insert(pending_ops.size(), op);
    endtask

    task automatic push_reg(input logic [CFG_IDX_W-1:0] ridx, input logic [COORD_W-1:0] value);
        pending_op_t op;
        op = '{OP_REG_WRITE, 1'b0, '0, 1'b0, ridx, value};
        pending_ops.insert(pending_ops.size(), op);
    endtask

    task automatic push_settle();
        pending_op_t op;
        op = '{OP_SETTLE, 1'b0, '0, 1'b0, '0, '0};
        pending_ops.insert(pending_ops.size(), op);
    endtask

    function automatic logic [COORD_W-1:0] random_base();
        logic [COORD_W-1:0] v;
        case ($urandom_range(9))
            0:       v = $urandom_range(1);
            1:       v = $urandom_range(31, 17);
            default: v = $urandom_range(16, 2);
        endcase
        // bits above the register width must be dropped
        if ($urandom_range(7) == 0)
            v = v | ($urandom & 32'hFFFF_FFE0);
        return v;
    endfunction

    function automatic logic [COORD_W-1:0] random_origin();
        logic [COORD_W-1:0] v;
        case ($urandom_range(7))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = '0;
            3:       v = {{8{$urandom_range(1) == 1}}, 24'($urandom)};
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [COORD_W-1:0] random_size();
        logic [COORD_W-1:0] v;
        case ($urandom_range(7))
            0:       v = '0;
            1:       v = 32'hFFFF_FFFF;
            2:       v = 32'h0001_0000;
            3:       v = $urandom_range(32'h000F_FFFF);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_index();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(7))
            0:       v = $urandom_range(15);
            1:       v = '1;
            2:       v = SAMPLE_W'(1) << $urandom_range(SAMPLE_W - 1);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // driver: one operation at a time, config and settle only once the block is idle
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_taken)
                start = 1'b0;
            if (cfg_taken)
                cfg_valid = 1'b0;
            if (!start && !cfg_valid && pending_ops.size() != 0)
            begin
                head_op = pending_ops[0];
                if (head_op.kind == OP_POINT)
                begin
                    if (!(head_op.gappy && $urandom_range(99) < 19))
                    begin
                        start = 1'b1;
                        sample_index = head_op.index;
                        last_in = head_op.last;
                        void'(pending_ops.pop_front());
                    end
                end
                else if (points_due.size() == 0 && !busy)
                begin
                    if (head_op.kind == OP_REG_WRITE)
                    begin
                        cfg_valid = 1'b1;
                        cfg_index = head_op.reg_idx;
                        cfg_data = head_op.value;
                    end
                    void'(pending_ops.pop_front());
                end
            end
        end
    end

    // monitor: register updates, expected points on each command transfer, result checks
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            item_taken <= start && !busy;
            cfg_taken <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready)
            begin
                reg_writes++;
                case (cfg_index)
                    CFG_BASE_X:      cur_base_x = cfg_data[BASE_W-1:0];
                    CFG_BASE_Y:      cur_base_y = cfg_data[BASE_W-1:0];
                    CFG_ORIGIN_X:    cur_origin_x = cfg_data;
                    CFG_ORIGIN_Y:    cur_origin_y = cfg_data;
                    CFG_VIEW_WIDTH:  cur_width = cfg_data;
                    CFG_VIEW_HEIGHT: cur_height = cfg_data;
                    default:         ;
                endcase
            end
            if (done)
            begin
                if (points_due.size() == 0)
                begin
                    $error("point out with none pending: x=%h y=%h last=%b",
                           point_x, point_y, last_out);
                    errors++;
                end
                else
                begin
                    got_point = points_due.pop_front();
                    points_checked++;
                    if (point_x !== got_point.x)
                    begin
                        $error("point_x: expected %h, got %h", got_point.x, point_x);
                        errors++;
                    end
                    if (point_y !== got_point.y)
                    begin
                        $error("point_y: expected %h, got %h", got_point.y, point_y);
                        errors++;
                    end
                    if (last_out !== got_point.last)
                    begin
                        $error("last_out: expected %b, got %b", got_point.last, last_out);
                        errors++;
                    end
                end
            end
            if (start && !busy)
                points_due.insert(points_due.size(), predict_point(sample_index, last_in));
            if ((start && !busy) || (cfg_valid && cfg_ready) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("halton_point_generator_top test failed");
                $finish;
            end
        end
    end

    initial
    begin
        int random_points;
        int phase;
        int run_len;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        sample_index = '0;
        last_in = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_taken = 1'b0;
        cfg_taken = 1'b0;
        errors = 0;
        points_checked = 0;
        reg_writes = 0;
        quiet_cycles = 0;
        cur_base_x = 5'd2;
        cur_base_y = 5'd3;
        cur_origin_x = '0;
        cur_origin_y = '0;
        cur_width = 32'h0001_0000;
        cur_height = 32'h0001_0000;

        // reset values: index zero gives the origin
        push_point(20'h00000, 1'b0, 1'b1);
        push_point(20'h00001, 1'b1, 1'b1);
        push_point(20'h00002, 1'b0, 1'b1);
        push_point(20'h00003, 1'b0, 1'b1);
        push_point(20'hFFFFF, 1'b1, 1'b1);
        push_point(20'h80000, 1'b0, 1'b1);
        push_point(20'h55555, 1'b1, 1'b1);

        // top base, base below range, x overflows past the top
        push_reg(CFG_BASE_X, 32'd16);
        push_reg(CFG_BASE_Y, 32'd0);
        push_reg(CFG_ORIGIN_X, 32'h7FFF_0000);
        push_reg(CFG_ORIGIN_Y, 32'h8000_0000);
        push_reg(CFG_VIEW_WIDTH, 32'hFFFF_FFFF);
        push_reg(CFG_VIEW_HEIGHT, 32'h0000_0000);
        push_point(20'h00000, 1'b0, 1'b1);
        push_point(20'hFFFFF, 1'b1, 1'b1);
        push_point(20'hAAAAA, 1'b0, 1'b1);
        push_point(20'h00001, 1'b1, 1'b1);

        // base 1 and base 31; writes to unmapped indexes must change nothing
        push_reg(CFG_BASE_X, 32'd1);
        push_reg(CFG_BASE_Y, 32'd31);
        push_reg(CFG_ORIGIN_X, 32'h7FFF_FFFF);
        push_reg(CFG_ORIGIN_Y, 32'hFFFF_0000);
        push_reg(CFG_VIEW_WIDTH, 32'h0001_0000);
        push_reg(CFG_VIEW_HEIGHT, 32'h0002_0000);
        push_reg(CFG_UNMAPPED_LO, 32'hFFFF_FFFF);
        push_reg(CFG_UNMAPPED_HI, 32'hFFFF_FFFF);
        push_point(20'h00000, 1'b0, 1'b1);
        push_point(20'h00001, 1'b1, 1'b1);
        push_point(20'h12345, 1'b0, 1'b1);
        push_point(20'hFFFFF, 1'b1, 1'b1);

        push_reg(CFG_BASE_X, 32'd17);
        push_reg(CFG_ORIGIN_X, 32'h0000_0000);
        push_reg(CFG_ORIGIN_Y, 32'h0000_0000);
        push_reg(CFG_VIEW_WIDTH, 32'h0064_0000);
        push_reg(CFG_VIEW_HEIGHT, 32'h0064_0000);
        for (int i = 1; i <= 5; i++)
            push_point(SAMPLE_W'(i), 1'(i), 1'b1);

        // sender waits for the block to drain at least once
        push_settle();

        random_points = 0;
        phase = 0;
        while (random_points < RANDOM_POINTS)
        begin
            if (phase == 0 || $urandom_range(1) == 1)
                push_reg(CFG_BASE_X, random_base());
            if (phase == 0 || $urandom_range(1) == 1)
                push_reg(CFG_BASE_Y, random_base());
            if (phase == 0 || $urandom_range(1) == 1)
                push_reg(CFG_ORIGIN_X, random_origin());
            if (phase == 0 || $urandom_range(1) == 1)
                push_reg(CFG_ORIGIN_Y, random_origin());
            if (phase == 0 || $urandom_range(1) == 1)
                push_reg(CFG_VIEW_WIDTH, random_size());
            if (phase == 0 || $urandom_range(1) == 1)
                push_reg(CFG_VIEW_HEIGHT, random_size());
            if ($urandom_range(7) == 0)
                push_reg($urandom_range(1) ? CFG_UNMAPPED_HI : CFG_UNMAPPED_LO, $urandom);
            run_len = $urandom_range(80, 20);
            for (int i = 0; i < run_len; i++)
            begin
                // phases 6 to 9 run back to back with no sender gaps
                push_point(random_index(), 1'($urandom_range(1)), !(phase >= 6 && phase <= 9));
                if ($urandom_range(59) == 0)
                    push_settle();
            end
            random_points += run_len;
            phase++;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_ops.size() != 0 || start || cfg_valid || points_due.size() != 0)
            @(negedge clk);
        repeat (100) @(posedge clk);

        $display("checked %0d points over %0d register writes (%0d config phases),",
                 points_checked, reg_writes, phase + 4);
        $display("bases 0 to 31, origins and view sizes at both extremes, saturating sums");
        if (errors == 0)
            $display("halton_point_generator_top test passed");
        else
            $display("halton_point_generator_top test failed");
        $finish;
    end

endmodule
